// ===== rtl/hpq_pkg.sv =====
// Shared types, codes and the microcode program of the binary heap priority queue.
package hpq_pkg;

  // Request kinds carried in s_tuser.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operations, one per step.
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_CLEAR     = 4'd2,
    OP_FULL      = 4'd3,
    OP_EMPTY     = 4'd4,
    OP_PUSH_SLOT = 4'd5,
    OP_UP_MOVE   = 4'd6,
    OP_TAKE_ROOT = 4'd7,
    OP_LD_CUR    = 4'd8,
    OP_BEST_INIT = 4'd9,
    OP_PICK_LC   = 4'd10,
    OP_PICK_RC   = 4'd11,
    OP_DN_MOVE   = 4'd12,
    OP_EMIT      = 4'd13
  } op_t;

  // Memory read address select.
  typedef enum logic [2:0] {
    RA_NONE   = 3'd0,
    RA_ZERO   = 3'd1,
    RA_LAST   = 3'd2,
    RA_PARENT = 3'd3,
    RA_LC     = 3'd4,
    RA_RC     = 3'd5
  } rd_sel_t;

  // Memory write select; the write address is always the hole slot.
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_RD   = 2'd1,
    WR_CUR  = 2'd2,
    WR_BEST = 2'd3
  } wr_sel_t;

  // Jump conditions. COND_NEXT never jumps.
  typedef enum logic [3:0] {
    COND_NEXT      = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_IN     = 4'd2,
    COND_IS_PUSH   = 4'd3,
    COND_IS_POP    = 4'd4,
    COND_NOT_CLEAR = 4'd5,
    COND_FULL      = 4'd6,
    COND_SLOT_ZERO = 4'd7,
    COND_NOT_ABOVE = 4'd8,
    COND_EMPTY     = 4'd9,
    COND_NO_LC     = 4'd10,
    COND_NO_RC     = 4'd11,
    COND_BEST_SELF = 4'd12,
    COND_OUT_BUSY  = 4'd13
  } cond_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd;
    wr_sel_t wr;
    cond_t   cond;
    upc_t    target;
  } ucode_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic is_push;
    logic is_pop;
    logic is_clear;
    logic full;
    logic slot_zero;
    logic cur_above;
    logic empty;
    logic no_lc;
    logic no_rc;
    logic best_self;
    logic out_busy;
  } hpq_flags_t;

  // Entry points of the program.
  localparam upc_t S_WAIT     = 5'd0;
  localparam upc_t S_PUSH     = 5'd5;
  localparam upc_t S_UP       = 5'd7;
  localparam upc_t S_UPDONE   = 5'd10;
  localparam upc_t S_SETFULL  = 5'd11;
  localparam upc_t S_POP      = 5'd12;
  localparam upc_t S_DN       = 5'd15;
  localparam upc_t S_DNCHK    = 5'd18;
  localparam upc_t S_DNDONE   = 5'd20;
  localparam upc_t S_FIN      = 5'd21;
  localparam upc_t S_EMIT     = 5'd22;
  localparam upc_t S_SETEMPTY = 5'd24;

  function automatic ucode_t uw(input op_t o, input rd_sel_t r, input wr_sel_t w,
                                input cond_t c, input upc_t t);
    ucode_t u;
    u = '{op: o, rd: r, wr: w, cond: c, target: t};
    return u;
  endfunction

  // The control store. Read data from the memory shows in the step after the read.
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t u;
    case (pc)
      5'd0:  u = uw(OP_ACCEPT,    RA_NONE,   WR_NONE, COND_NO_IN,     S_WAIT);
      5'd1:  u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_IS_PUSH,   S_PUSH);
      5'd2:  u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_IS_POP,    S_POP);
      5'd3:  u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_NOT_CLEAR, S_FIN);
      5'd4:  u = uw(OP_CLEAR,     RA_NONE,   WR_NONE, COND_ALWAYS,    S_FIN);
      5'd5:  u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_FULL,      S_SETFULL);
      5'd6:  u = uw(OP_PUSH_SLOT, RA_NONE,   WR_NONE, COND_NEXT,      S_WAIT);
      5'd7:  u = uw(OP_NONE,      RA_PARENT, WR_NONE, COND_SLOT_ZERO, S_UPDONE);
      5'd8:  u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_NOT_ABOVE, S_UPDONE);
      5'd9:  u = uw(OP_UP_MOVE,   RA_NONE,   WR_RD,   COND_ALWAYS,    S_UP);
      5'd10: u = uw(OP_NONE,      RA_NONE,   WR_CUR,  COND_ALWAYS,    S_FIN);
      5'd11: u = uw(OP_FULL,      RA_NONE,   WR_NONE, COND_ALWAYS,    S_FIN);
      5'd12: u = uw(OP_NONE,      RA_ZERO,   WR_NONE, COND_EMPTY,     S_SETEMPTY);
      5'd13: u = uw(OP_TAKE_ROOT, RA_LAST,   WR_NONE, COND_NEXT,      S_WAIT);
      5'd14: u = uw(OP_LD_CUR,    RA_NONE,   WR_NONE, COND_NEXT,      S_WAIT);
      5'd15: u = uw(OP_BEST_INIT, RA_LC,     WR_NONE, COND_NO_LC,     S_DNDONE);
      5'd16: u = uw(OP_PICK_LC,   RA_RC,     WR_NONE, COND_NO_RC,     S_DNCHK);
      5'd17: u = uw(OP_PICK_RC,   RA_NONE,   WR_NONE, COND_NEXT,      S_WAIT);
      5'd18: u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_BEST_SELF, S_DNDONE);
      5'd19: u = uw(OP_DN_MOVE,   RA_NONE,   WR_BEST, COND_ALWAYS,    S_DN);
      5'd20: u = uw(OP_NONE,      RA_NONE,   WR_CUR,  COND_NEXT,      S_WAIT);
      5'd21: u = uw(OP_NONE,      RA_ZERO,   WR_NONE, COND_NEXT,      S_WAIT);
      5'd22: u = uw(OP_EMIT,      RA_NONE,   WR_NONE, COND_OUT_BUSY,  S_EMIT);
      5'd23: u = uw(OP_NONE,      RA_NONE,   WR_NONE, COND_ALWAYS,    S_WAIT);
      5'd24: u = uw(OP_EMPTY,     RA_NONE,   WR_NONE, COND_ALWAYS,    S_FIN);
      default: u = uw(OP_NONE,    RA_NONE,   WR_NONE, COND_ALWAYS,    S_WAIT);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/hpq_mem.sv =====
// Heap entry store: one write port and one registered read port.
module hpq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads; the sequencer relies on that.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/hpq_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module hpq_useq (
  input  logic               clk,
  input  logic               rst,
  input  hpq_pkg::hpq_flags_t flags,
  output hpq_pkg::ucode_t    ctrl
);
  import hpq_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic take;

  assign ctrl = ucode_rom(upc);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_IN:     take = !flags.in_valid;
      COND_IS_PUSH:   take = flags.is_push;
      COND_IS_POP:    take = flags.is_pop;
      COND_NOT_CLEAR: take = !flags.is_clear;
      COND_FULL:      take = flags.full;
      COND_SLOT_ZERO: take = flags.slot_zero;
      COND_NOT_ABOVE: take = !flags.cur_above;
      COND_EMPTY:     take = flags.empty;
      COND_NO_LC:     take = flags.no_lc;
      COND_NO_RC:     take = flags.no_rc;
      COND_BEST_SELF: take = flags.best_self;
      COND_OUT_BUSY:  take = flags.out_busy;
      default:        take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/binary_heap_priority_queue_top.sv =====
// Top level of the binary heap priority queue: stream ports, datapath, store and sequencer.
//
// A priority queue of up to DEPTH entries, each a KEY_BITS unsigned key with a
// PAYLOAD_BITS payload, kept as a binary heap in a single-port-read memory. Each
// input transaction is one request (push, pop or clear, chosen by s_tuser) and
// produces exactly one result transaction that reports the popped entry, the new
// top entry, the entry count and a status. The order register (written on the cfg
// channel; the user must write it only while the block is idle, as the block does
// not enforce it) selects smallest-key-first (0) or largest-key-first (1);
// changing it does not reorder entries already held. A push into a full heap is
// rejected with status 1 and a pop of an empty heap returns status 2, both
// leaving the heap unchanged. Requests are handled one at a time by a microcoded
// sequencer stepping a small datapath; every heap level walked costs memory round
// trips through the one registered read port, so a push or a pop takes longer the
// more levels the entry moves (at most log2 of DEPTH). The result sits in an
// output register, so a result waiting for m_tready only holds the sequencer at
// the step that loads the next result.
module binary_heap_priority_queue_top #(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS,
  localparam int IN_W   = ((ENT_W + 7) / 8) * 8,
  localparam int OUT_FW = 2 * ENT_W + CNT_W + 3,
  localparam int OUT_W  = ((OUT_FW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Request channel.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // item_key, item_payload, zero fill
  input  logic [1:0]       s_tuser,   // kind
  // Result channel.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // popped_key, popped_payload, top_key, top_payload,
                                      // entry_total, is_empty, status, zero fill
  output logic [0:0]       m_tuser,   // popped_valid
  // Order register write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data   // order_max
);
  import hpq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LC_W  = IDX_W + 2;   // holds 2*slot+2 for any slot below DEPTH

  function automatic logic ranks_above(input logic om, input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b);
    return om ? (a > b) : (a < b);
  endfunction

  ucode_t     ctrl;
  hpq_flags_t flags;

  // Architectural and working registers.
  logic             order_max;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] slot;          // current hole position
  logic [1:0]       kind;
  logic [ENT_W-1:0] cur;           // entry being sifted
  logic [ENT_W-1:0] best;
  logic [IDX_W-1:0] best_idx;
  logic             best_self;
  logic             pop_valid;
  logic [ENT_W-1:0] pop_ent;
  logic [1:0]       status;

  // Output register.
  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic             out_busy;

  // Memory interface.
  logic             mem_wr_en;
  logic [ENT_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0] rd_data;

  // Index arithmetic.
  logic [IDX_W-1:0] parent;
  logic [LC_W-1:0]  lc;
  logic [LC_W-1:0]  rc;
  logic [LC_W-1:0]  count_w;
  logic [IDX_W-1:0] last;
  logic [ENT_W-1:0] top_ent;
  logic             in_fire;

  assign parent  = (slot - IDX_W'(1)) >> 1;
  assign lc      = {1'b0, slot, 1'b1};
  assign rc      = lc + LC_W'(1);
  assign count_w = LC_W'(count);
  assign last    = IDX_W'(count - CNT_W'(1));
  assign top_ent = (count != '0) ? rd_data : '0;

  assign cfg_ready = 1'b1;
  assign s_tready  = (ctrl.op == OP_ACCEPT) && !rst;
  assign in_fire   = s_tvalid && s_tready;
  assign out_busy  = out_valid && !m_tready;

  assign flags.in_valid  = s_tvalid;
  assign flags.is_push   = (kind == KIND_PUSH);
  assign flags.is_pop    = (kind == KIND_POP);
  assign flags.is_clear  = (kind == KIND_CLEAR);
  assign flags.full      = (count == CNT_W'(DEPTH));
  assign flags.slot_zero = (slot == '0);
  assign flags.cur_above = ranks_above(order_max, cur[KEY_BITS-1:0], rd_data[KEY_BITS-1:0]);
  assign flags.empty     = (count == '0);
  assign flags.no_lc     = (lc >= count_w);
  assign flags.no_rc     = (rc >= count_w);
  assign flags.best_self = best_self;
  assign flags.out_busy  = out_busy;

  hpq_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  always_comb begin
    case (ctrl.rd)
      RA_ZERO:   mem_rd_addr = '0;
      RA_LAST:   mem_rd_addr = last;
      RA_PARENT: mem_rd_addr = parent;
      RA_LC:     mem_rd_addr = lc[IDX_W-1:0];
      RA_RC:     mem_rd_addr = rc[IDX_W-1:0];
      default:   mem_rd_addr = '0;
    endcase
    case (ctrl.wr)
      WR_RD:   mem_wr_data = rd_data;
      WR_CUR:  mem_wr_data = cur;
      WR_BEST: mem_wr_data = best;
      default: mem_wr_data = cur;
    endcase
  end

  assign mem_rd_en = (ctrl.rd != RA_NONE);
  assign mem_wr_en = (ctrl.wr != WR_NONE);

  hpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (slot),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_max <= 1'b0;
      count     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_max <= cfg_data;
      end
      case (ctrl.op)
        OP_CLEAR:     count <= '0;
        OP_PUSH_SLOT: count <= count + CNT_W'(1);
        OP_TAKE_ROOT: count <= count - CNT_W'(1);
        default:      count <= count;
      endcase
    end
  end

  // Working registers of the sift; the hole method writes each moved entry once.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          cur       <= s_tdata[ENT_W-1:0];
          kind      <= s_tuser;
          pop_valid <= 1'b0;
          pop_ent   <= '0;
          status    <= ST_OK;
        end
      end
      OP_FULL:      status <= ST_FULL;
      OP_EMPTY:     status <= ST_EMPTY;
      OP_PUSH_SLOT: slot <= count[IDX_W-1:0];
      OP_UP_MOVE:   slot <= parent;
      OP_TAKE_ROOT: begin
        pop_valid <= 1'b1;
        pop_ent   <= rd_data;
        slot      <= '0;
      end
      OP_LD_CUR:    cur <= rd_data;
      OP_BEST_INIT: begin
        best      <= cur;
        best_self <= 1'b1;
      end
      OP_PICK_LC: begin
        if (ranks_above(order_max, rd_data[KEY_BITS-1:0], best[KEY_BITS-1:0])) begin
          best      <= rd_data;
          best_idx  <= lc[IDX_W-1:0];
          best_self <= 1'b0;
        end
      end
      OP_PICK_RC: begin
        if (ranks_above(order_max, rd_data[KEY_BITS-1:0], best[KEY_BITS-1:0])) begin
          best      <= rd_data;
          best_idx  <= rc[IDX_W-1:0];
          best_self <= 1'b0;
        end
      end
      OP_DN_MOVE:   slot <= best_idx;
      default: begin
      end
    endcase
  end

  // Result register; a new result may load in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.op == OP_EMIT) && !out_busy) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_EMIT) && !out_busy) begin
      out_data   <= OUT_W'({status, (count == '0), count, top_ent, pop_ent});
      m_tuser[0] <= pop_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== rtl/hpq_checker.sv =====
// Port-level assertions for the binary heap priority queue and their bind.
module hpq_checker #(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS,
  localparam int OUT_FW = 2 * ENT_W + CNT_W + 3,
  localparam int OUT_W  = ((OUT_FW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [0:0]       m_tuser
);
  import hpq_pkg::*;

  localparam int CNT_LO = 2 * ENT_W;
  localparam int EMP_AT = CNT_LO + CNT_W;
  localparam int ST_LO  = EMP_AT + 1;

  logic [CNT_W-1:0] total;
  logic             empty;
  logic [1:0]       stat;

  assign total = m_tdata[CNT_LO +: CNT_W];
  assign empty = m_tdata[EMP_AT];
  assign stat  = m_tdata[ST_LO +: 2];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> total <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> empty == (total == '0))
    else $error("empty flag disagrees with count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat == ST_FULL |-> total == CNT_W'(DEPTH))
    else $error("push rejected while not full");

  a_popok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> stat == ST_OK)
    else $error("popped entry with error status");

endmodule

bind binary_heap_priority_queue_top hpq_checker #(
  .DEPTH        (DEPTH),
  .KEY_BITS     (KEY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_hpq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
